### hw/rtl/rrts_pkg.sv
// rrts_pkg: event, status and thread-state codes shared by the round-robin
// thread scheduler files.
// No dependencies.
`default_nettype none

package rrts_pkg;

  localparam int KIND_W   = 3;
  localparam int STATUS_W = 3;
  localparam int TSTATE_W = 2;
  localparam int TID_W    = 4;

  // event kinds
  localparam logic [KIND_W-1:0] K_CREATE  = 3'd0;
  localparam logic [KIND_W-1:0] K_UNBLOCK = 3'd1;
  localparam logic [KIND_W-1:0] K_START   = 3'd2;
  localparam logic [KIND_W-1:0] K_YIELD   = 3'd3;
  localparam logic [KIND_W-1:0] K_BLOCK   = 3'd4;
  localparam logic [KIND_W-1:0] K_FINISH  = 3'd5;

  // per-thread state codes
  localparam logic [TSTATE_W-1:0] TS_FREE    = 2'd0;
  localparam logic [TSTATE_W-1:0] TS_READY   = 2'd1;
  localparam logic [TSTATE_W-1:0] TS_RUNNING = 2'd2;
  localparam logic [TSTATE_W-1:0] TS_BLOCKED = 2'd3;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_SWITCHED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_QUEUED   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_ALL_DONE = 3'd2;
  localparam logic [STATUS_W-1:0] ST_DEADLOCK = 3'd3;
  localparam logic [STATUS_W-1:0] ST_ILLEGAL  = 3'd4;

endpackage

`default_nettype wire

### hw/rtl/rrts_ram.sv
// rrts_ram: generic single-write, single-read synchronous RAM with a
// registered read port. No dependencies.
`default_nettype none

module rrts_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### hw/rtl/round_robin_thread_scheduler.sv
// round_robin_thread_scheduler: top level of the round-robin thread scheduler.
// Depends on rrts_pkg (codes) and rrts_ram (thread-state table, ready fifo).
`default_nettype none

// channel  | direction | payload
// ---------+-----------+------------------------------------------------------
// in_      | slave     | tuser: kind; tdata: thread_id
// out_     | master    | tdata: running_id; tuser: running_valid, status
//
// an event that dispatches a thread passes through idle (with table read),
// execute, second table write and result load; any other event skips the
// second write. the single write port of the thread-state ram sets the extra
// state on dispatch.
// one event is in flight at a time; in_tready is high only while idle.
// a result waiting in the output register does not block the next accept;
// a new result waits in the load state until the register is free.
// rst_n (synchronous) clears the table valid bits, fifo pointers and counts.

module round_robin_thread_scheduler #(
  parameter int MAX_THREADS = 16
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  // input events
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [3:0] thread_id
  input  wire logic [2:0] in_tuser,   // [2:0] kind
  // results
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic      [7:0] out_tdata,  // [3:0] running_id
  output logic      [3:0] out_tuser   // [0] running_valid, [3:1] status
);

  import rrts_pkg::*;

  localparam int IDW  = $clog2(MAX_THREADS);
  localparam int CNTW = $clog2(MAX_THREADS + 1);
  localparam logic [IDW-1:0] LAST_IDX = IDW'(MAX_THREADS - 1);

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_WR2, S_OUT} state_t;

  // control state
  state_t                 state_r,   state_nxt;
  logic [IDW-1:0]         head_r,    head_nxt;
  logic [IDW-1:0]         tail_r,    tail_nxt;
  logic [CNTW-1:0]        rdy_cnt_r, rdy_cnt_nxt;
  logic [CNTW-1:0]        blk_cnt_r, blk_cnt_nxt;
  logic [IDW-1:0]         cur_r,     cur_nxt;
  logic                   curv_r,    curv_nxt;
  logic [MAX_THREADS-1:0] tsv_r,     tsv_nxt;   // table entry written since reset
  logic                   out_v_r,   out_v_nxt;
  // event / result payload
  logic [KIND_W-1:0]      kind_r,    kind_nxt;
  logic [IDW-1:0]         id_r,      id_nxt;
  logic                   id_ok_r,   id_ok_nxt;
  logic                   rdv_r,     rdv_nxt;   // valid bit of the entry read
  logic [STATUS_W-1:0]    st_r,      st_nxt;
  logic [TID_W-1:0]       out_id_r,  out_id_nxt;
  logic                   out_rv_r,  out_rv_nxt;
  logic [STATUS_W-1:0]    out_st_r,  out_st_nxt;

  // ram ports
  logic                ts_we;
  logic [IDW-1:0]      ts_waddr, ts_raddr;
  logic [TSTATE_W-1:0] ts_wdata, ts_rdata;
  logic                ff_we;
  logic [IDW-1:0]      ff_waddr;
  logic [IDW-1:0]      ff_wdata, ff_rdata;

  rrts_ram #(.WIDTH(TSTATE_W), .DEPTH(MAX_THREADS)) u_tstate (
    .clk   (clk),
    .we    (ts_we),
    .waddr (ts_waddr),
    .wdata (ts_wdata),
    .raddr (ts_raddr),
    .rdata (ts_rdata)
  );

  rrts_ram #(.WIDTH(IDW), .DEPTH(MAX_THREADS)) u_rdyfifo (
    .clk   (clk),
    .we    (ff_we),
    .waddr (ff_waddr),
    .wdata (ff_wdata),
    .raddr (head_r),
    .rdata (ff_rdata)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_v_r;
  assign out_tdata  = {4'b0000, out_id_r};
  assign out_tuser  = {out_st_r, out_rv_r};

  always_comb begin
    logic [TSTATE_W-1:0] id_state;
    logic                push;
    logic [IDW-1:0]      push_id;
    logic                disp;
    logic [CNTW-1:0]     cnt_pushed;
    logic [IDW-1:0]      pop_id;
    logic [CNTW-1:0]     blk_upd;

    id_state   = rdv_r ? ts_rdata : TS_FREE;
    push       = 1'b0;
    push_id    = id_r;
    disp       = 1'b0;
    cnt_pushed = rdy_cnt_r;
    pop_id     = ff_rdata;
    blk_upd    = blk_cnt_r;

    state_nxt   = state_r;
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    rdy_cnt_nxt = rdy_cnt_r;
    blk_cnt_nxt = blk_cnt_r;
    cur_nxt     = cur_r;
    curv_nxt    = curv_r;
    tsv_nxt     = tsv_r;
    kind_nxt    = kind_r;
    id_nxt      = id_r;
    id_ok_nxt   = id_ok_r;
    rdv_nxt     = rdv_r;
    st_nxt      = st_r;
    out_id_nxt  = out_id_r;
    out_rv_nxt  = out_rv_r;
    out_st_nxt  = out_st_r;
    out_v_nxt   = out_v_r;

    ts_we    = 1'b0;
    ts_waddr = cur_r;
    ts_wdata = TS_FREE;
    ts_raddr = IDW'(in_tdata[3:0]);
    ff_we    = 1'b0;
    ff_waddr = tail_r;
    ff_wdata = id_r;

    // the output register drains independently of event processing
    if (out_v_r && out_tready) begin
      out_v_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          kind_nxt  = in_tuser;
          id_nxt    = IDW'(in_tdata[3:0]);
          id_ok_nxt = (int'(in_tdata[3:0]) < MAX_THREADS);
          rdv_nxt   = tsv_r[IDW'(in_tdata[3:0])];
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        // table entry of id_r and fifo head are now on the ram outputs
        st_nxt    = ST_ILLEGAL;
        state_nxt = S_OUT;
        case (kind_r)
          K_CREATE: begin
            if (id_ok_r && id_state == TS_FREE) begin
              ts_we    = 1'b1;
              ts_waddr = id_r;
              ts_wdata = TS_READY;
              push     = 1'b1;
              st_nxt   = ST_QUEUED;
            end
          end
          K_UNBLOCK: begin
            if (id_ok_r && id_state == TS_BLOCKED) begin
              ts_we    = 1'b1;
              ts_waddr = id_r;
              ts_wdata = TS_READY;
              push     = 1'b1;
              if (blk_cnt_r != '0) begin
                blk_upd = blk_cnt_r - CNTW'(1);
              end
              st_nxt = ST_QUEUED;
            end
          end
          K_START: begin
            disp = !curv_r;
          end
          K_YIELD: begin
            if (curv_r) begin
              ts_we    = 1'b1;
              ts_waddr = cur_r;
              ts_wdata = TS_READY;
              push     = 1'b1;
              push_id  = cur_r;
              disp     = 1'b1;
            end
          end
          K_BLOCK: begin
            if (curv_r) begin
              ts_we    = 1'b1;
              ts_waddr = cur_r;
              ts_wdata = TS_BLOCKED;
              blk_upd  = blk_cnt_r + CNTW'(1);
              disp     = 1'b1;
            end
          end
          K_FINISH: begin
            if (curv_r) begin
              ts_we    = 1'b1;
              ts_waddr = cur_r;
              ts_wdata = TS_FREE;
              disp     = 1'b1;
            end
          end
          default: begin
          end
        endcase

        if (ts_we) begin
          tsv_nxt[ts_waddr] = 1'b1;
        end

        // append to the ready fifo
        if (push) begin
          ff_we      = 1'b1;
          ff_waddr   = tail_r;
          ff_wdata   = push_id;
          tail_nxt   = (tail_r == LAST_IDX) ? '0 : tail_r + IDW'(1);
          cnt_pushed = rdy_cnt_r + CNTW'(1);
          // empty fifo: the entry just pushed is the head, ram data is stale
          if (rdy_cnt_r == '0) begin
            pop_id = push_id;
          end
        end
        rdy_cnt_nxt = cnt_pushed;
        blk_cnt_nxt = blk_upd;

        // hand the processor to the head of the fifo
        if (disp) begin
          if (cnt_pushed == '0) begin
            curv_nxt = 1'b0;
            cur_nxt  = '0;
            st_nxt   = (blk_upd == '0) ? ST_ALL_DONE : ST_DEADLOCK;
          end else begin
            cur_nxt     = pop_id;
            curv_nxt    = 1'b1;
            head_nxt    = (head_r == LAST_IDX) ? '0 : head_r + IDW'(1);
            rdy_cnt_nxt = cnt_pushed - CNTW'(1);
            st_nxt      = ST_SWITCHED;
            state_nxt   = S_WR2;
          end
        end
      end

      S_WR2: begin
        // second table write: mark the dispatched thread running
        ts_we           = 1'b1;
        ts_waddr        = cur_r;
        ts_wdata        = TS_RUNNING;
        tsv_nxt[cur_r]  = 1'b1;
        state_nxt       = S_OUT;
      end

      S_OUT: begin
        if (!out_v_r || out_tready) begin
          out_v_nxt  = 1'b1;
          out_id_nxt = curv_r ? TID_W'(cur_r) : '0;
          out_rv_nxt = curv_r;
          out_st_nxt = st_r;
          state_nxt  = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      head_r    <= '0;
      tail_r    <= '0;
      rdy_cnt_r <= '0;
      blk_cnt_r <= '0;
      cur_r     <= '0;
      curv_r    <= 1'b0;
      tsv_r     <= '0;
      out_v_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      head_r    <= head_nxt;
      tail_r    <= tail_nxt;
      rdy_cnt_r <= rdy_cnt_nxt;
      blk_cnt_r <= blk_cnt_nxt;
      cur_r     <= cur_nxt;
      curv_r    <= curv_nxt;
      tsv_r     <= tsv_nxt;
      out_v_r   <= out_v_nxt;
    end
    kind_r   <= kind_nxt;
    id_r     <= id_nxt;
    id_ok_r  <= id_ok_nxt;
    rdv_r    <= rdv_nxt;
    st_r     <= st_nxt;
    out_id_r <= out_id_nxt;
    out_rv_r <= out_rv_nxt;
    out_st_r <= out_st_nxt;
  end

endmodule

`default_nettype wire

### verif/tb_round_robin_thread_scheduler.sv
// tb_round_robin_thread_scheduler: self-checking bench for the round-robin thread scheduler.
// Directed event table first, then random event sequences; every result is checked in order.
// Depends on rrts_pkg and round_robin_thread_scheduler.
module tb_round_robin_thread_scheduler;
  import rrts_pkg::*;

  localparam int NTHREADS       = 16;
  localparam int RX_HOLD_CYCLES = 150;   // long receiver hold-off, fills the block
  localparam int WATCHDOG_LIMIT = 1000;  // cycles with no transfer on either side
  localparam int RAND_PHASES    = 5;
  localparam int PHASE_ITEMS    = 110;

  // event kinds the block must reject
  localparam logic [KIND_W-1:0] KIND_RSVD6 = 3'd6;
  localparam logic [KIND_W-1:0] KIND_RSVD7 = 3'd7;

  // one scheduler result, field by field
  typedef struct packed {
    logic [TID_W-1:0]    running_id;
    logic                running_valid;
    logic [STATUS_W-1:0] status;
  } sched_outcome_t;

  // a row of the directed table; typed rows carry their own expected result
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [TID_W-1:0]  tid;
    logic              typed;
    sched_outcome_t    outcome;
  } directed_row_t;

  localparam sched_outcome_t NOT_TYPED = '0;

  // weighting of legal events in the random part
  typedef enum logic [1:0] {MIX_FILL, MIX_DRAIN, MIX_EVEN} event_mix_t;

  localparam logic [KIND_W-1:0] LEGAL_KINDS [6] =
    '{K_CREATE, K_UNBLOCK, K_START, K_YIELD, K_BLOCK, K_FINISH};

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [7:0]          in_tdata;   // [3:0] thread_id
  logic [2:0]          in_tuser;   // [2:0] kind
  logic                out_tvalid;
  logic                out_tready;
  logic [7:0]          out_tdata;  // [3:0] running_id
  logic [3:0]          out_tuser;  // [0] running_valid, [3:1] status

  // shadow of the scheduler: thread table, ready ring, counts, running thread
  logic [TSTATE_W-1:0] slot_state [NTHREADS];
  logic [TID_W-1:0]    ready_ring [NTHREADS];
  logic [TID_W-1:0]    ring_head;
  logic [TID_W-1:0]    ring_tail;
  int                  ready_cnt;
  int                  blocked_cnt;
  logic [TID_W-1:0]    run_id;
  logic                run_ok;

  sched_outcome_t      pending_outcomes [$];
  int                  mismatches;
  int                  idle_cycles;

  // stimulus knobs, set per phase by the sender
  logic                tx_eager;
  logic                rx_eager;
  logic                rx_hold;
  event_mix_t          mix;

  // directed walk: reset state, every event kind, rejected events,
  // yield with an empty ring, deadlock, resume after deadlock, all done
  directed_row_t directed_rows [26] = '{
    '{K_START,    4'd0,  1'b1, '{4'd0,  1'b0, ST_ALL_DONE}},  // nothing created yet
    '{K_YIELD,    4'd0,  1'b1, '{4'd0,  1'b0, ST_ILLEGAL}},   // nothing running
    '{K_BLOCK,    4'd0,  1'b1, '{4'd0,  1'b0, ST_ILLEGAL}},
    '{K_FINISH,   4'd0,  1'b1, '{4'd0,  1'b0, ST_ILLEGAL}},
    '{KIND_RSVD6, 4'd5,  1'b1, '{4'd0,  1'b0, ST_ILLEGAL}},   // reserved kinds
    '{KIND_RSVD7, 4'd10, 1'b1, '{4'd0,  1'b0, ST_ILLEGAL}},
    '{K_UNBLOCK,  4'd3,  1'b1, '{4'd0,  1'b0, ST_ILLEGAL}},   // free, not blocked
    '{K_CREATE,   4'd0,  1'b1, '{4'd0,  1'b0, ST_QUEUED}},
    '{K_CREATE,   4'd15, 1'b1, '{4'd0,  1'b0, ST_QUEUED}},
    '{K_CREATE,   4'd15, 1'b1, '{4'd0,  1'b0, ST_ILLEGAL}},   // slot taken
    '{K_START,    4'd0,  1'b1, '{4'd0,  1'b1, ST_SWITCHED}},
    '{K_START,    4'd0,  1'b1, '{4'd0,  1'b1, ST_ILLEGAL}},   // already running
    '{K_YIELD,    4'd0,  1'b0, NOT_TYPED},
    '{K_BLOCK,    4'd0,  1'b0, NOT_TYPED},
    '{K_YIELD,    4'd0,  1'b0, NOT_TYPED},                    // ring empty, keeps running
    '{K_BLOCK,    4'd0,  1'b1, '{4'd0,  1'b0, ST_DEADLOCK}},
    '{K_CREATE,   4'd15, 1'b1, '{4'd0,  1'b0, ST_ILLEGAL}},   // blocked slot
    '{K_UNBLOCK,  4'd15, 1'b0, NOT_TYPED},
    '{K_START,    4'd0,  1'b0, NOT_TYPED},                    // resume after deadlock
    '{K_UNBLOCK,  4'd0,  1'b0, NOT_TYPED},
    '{K_FINISH,   4'd0,  1'b0, NOT_TYPED},
    '{K_CREATE,   4'd10, 1'b0, NOT_TYPED},
    '{K_CREATE,   4'd5,  1'b0, NOT_TYPED},
    '{K_FINISH,   4'd0,  1'b0, NOT_TYPED},
    '{K_FINISH,   4'd0,  1'b0, NOT_TYPED},
    '{K_FINISH,   4'd0,  1'b1, '{4'd0,  1'b0, ST_ALL_DONE}}   // last thread gone
  };

  round_robin_thread_scheduler #(
    .MAX_THREADS (NTHREADS)
  ) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // shadow scheduler
  // ---------------------------------------------------------------------------

  function automatic void ring_push(input logic [TID_W-1:0] id);
    ready_ring[ring_tail] = id;
    ring_tail++;                       // 4-bit pointer wraps with 16 slots
    ready_cnt++;
  endfunction

  // hand the processor to the oldest ready thread, or report why none runs
  function automatic logic [STATUS_W-1:0] run_next();
    if (ready_cnt == 0) begin
      run_ok = 1'b0;
      run_id = '0;
      return (blocked_cnt == 0) ? ST_ALL_DONE : ST_DEADLOCK;
    end
    run_id = ready_ring[ring_head];
    ring_head++;
    ready_cnt--;
    run_ok = 1'b1;
    slot_state[run_id] = TS_RUNNING;
    return ST_SWITCHED;
  endfunction

  // apply one accepted event and return the result it should produce;
  // any rejected event leaves the shadow untouched
  function automatic sched_outcome_t apply_event(input logic [KIND_W-1:0] kind,
                                                 input logic [TID_W-1:0]  tid);
    sched_outcome_t o;
    logic [STATUS_W-1:0] st;
    st = ST_ILLEGAL;
    case (kind)
      K_CREATE: if (slot_state[tid] == TS_FREE) begin
        slot_state[tid] = TS_READY;
        ring_push(tid);
        st = ST_QUEUED;
      end
      K_UNBLOCK: if (slot_state[tid] == TS_BLOCKED) begin
        slot_state[tid] = TS_READY;
        blocked_cnt--;
        ring_push(tid);
        st = ST_QUEUED;
      end
      K_START: if (!run_ok) begin
        st = run_next();
      end
      K_YIELD: if (run_ok) begin
        // an empty ring hands the same thread straight back
        slot_state[run_id] = TS_READY;
        ring_push(run_id);
        st = run_next();
      end
      K_BLOCK: if (run_ok) begin
        slot_state[run_id] = TS_BLOCKED;
        blocked_cnt++;
        run_ok = 1'b0;
        st = run_next();
      end
      K_FINISH: if (run_ok) begin
        slot_state[run_id] = TS_FREE;
        run_ok = 1'b0;
        st = run_next();
      end
      default: ;
    endcase
    o.running_id    = run_ok ? run_id : '0;
    o.running_valid = run_ok;
    o.status        = st;
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus generation
  // ---------------------------------------------------------------------------

  // random thread whose slot is in the given state; caller makes sure one exists
  function automatic logic [TID_W-1:0] pick_slot(input logic [TSTATE_W-1:0] want);
    logic [TID_W-1:0] cand [NTHREADS];
    int n;
    n = 0;
    for (int i = 0; i < NTHREADS; i++) begin
      if (slot_state[i] == want) begin
        cand[n] = TID_W'(i);
        n++;
      end
    end
    return cand[$urandom_range(0, n - 1)];
  endfunction

  // mostly legal events drawn against the shadow state, some raw noise
  task automatic choose_event(output logic [KIND_W-1:0] kind,
                              output logic [TID_W-1:0]  tid);
    int w [6];
    int base [6];
    int total;
    int r;
    int n_free;
    int n_blk;
    if ($urandom_range(0, 99) < 8) begin
      kind = KIND_W'($urandom_range(0, 7));
      tid  = TID_W'($urandom_range(0, NTHREADS - 1));
      return;
    end
    n_free = 0;
    n_blk  = 0;
    for (int i = 0; i < NTHREADS; i++) begin
      if (slot_state[i] == TS_FREE) n_free++;
      if (slot_state[i] == TS_BLOCKED) n_blk++;
    end
    case (mix)
      MIX_FILL:  base = '{6, 2, 3, 3, 1, 1};
      MIX_DRAIN: base = '{1, 1, 3, 2, 3, 4};
      default:   base = '{3, 2, 3, 3, 2, 2};
    endcase
    w[0] = (n_free > 0) ? base[0] : 0;
    w[1] = (n_blk > 0)  ? base[1] : 0;
    w[2] = !run_ok      ? base[2] : 0;
    w[3] = run_ok       ? base[3] : 0;
    w[4] = run_ok       ? base[4] : 0;
    w[5] = run_ok       ? base[5] : 0;
    total = 0;
    foreach (w[j]) total += w[j];
    r = $urandom_range(0, total - 1);
    kind = LEGAL_KINDS[0];
    for (int j = 0; j < 6; j++) begin
      if (r < w[j]) begin
        kind = LEGAL_KINDS[j];
        break;
      end
      r -= w[j];
    end
    // the id is ignored by start, yield, block and finish: keep it random
    if (kind == K_CREATE) tid = pick_slot(TS_FREE);
    else if (kind == K_UNBLOCK) tid = pick_slot(TS_BLOCKED);
    else tid = TID_W'($urandom_range(0, NTHREADS - 1));
  endtask

  // offer one event on the input channel and record its expected result at
  // the transfer; entered and left at a falling edge
  task automatic offer_event(input logic [KIND_W-1:0] kind,
                             input logic [TID_W-1:0]  tid,
                             input logic              typed,
                             input sched_outcome_t    typed_outcome);
    int gap;
    sched_outcome_t o;
    gap = tx_eager ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = kind;
    in_tdata  = {{(8 - TID_W){1'b0}}, tid};
    do @(posedge clk); while (!in_tready);
    o = apply_event(kind, tid);
    pending_outcomes.push_back(typed ? typed_outcome : o);
    @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // sender: reset, directed table, random phases, end of run
  // ---------------------------------------------------------------------------

  initial begin
    logic [KIND_W-1:0] k;
    logic [TID_W-1:0]  t;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = '0;
    tx_eager  = 1'b0;
    rx_eager  = 1'b0;
    rx_hold   = 1'b0;
    mix       = MIX_EVEN;
    mismatches = 0;
    for (int i = 0; i < NTHREADS; i++) begin
      slot_state[i] = TS_FREE;
      ready_ring[i] = '0;
    end
    ring_head   = '0;
    ring_tail   = '0;
    ready_cnt   = 0;
    blocked_cnt = 0;
    run_id      = '0;
    run_ok      = 1'b0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_rows[i])
      offer_event(directed_rows[i].kind, directed_rows[i].tid,
                  directed_rows[i].typed, directed_rows[i].outcome);

    for (int p = 0; p < RAND_PHASES; p++) begin
      case (p)
        0: begin mix = MIX_FILL;  tx_eager = 1'b0; rx_eager = 1'b0; end
        1: begin mix = MIX_EVEN;  tx_eager = 1'b1; rx_eager = 1'b1; end  // no idling
        2: begin mix = MIX_DRAIN; tx_eager = 1'b1; rx_eager = 1'b0; end
        3: begin mix = MIX_EVEN;  tx_eager = 1'b1; rx_eager = 1'b0; end
        default: begin mix = MIX_DRAIN; tx_eager = 1'b0; rx_eager = 1'b1; end
      endcase
      // sender pause: let every outstanding result come back first
      if (p == 3) begin
        in_tvalid = 1'b0;
        while (pending_outcomes.size() != 0) @(negedge clk);
      end
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // receiver goes quiet while events keep coming, so input backs up
        if (p == 2 && i == 5) rx_hold = 1'b1;
        choose_event(k, t);
        offer_event(k, t, 1'b0, NOT_TYPED);
      end
    end
    in_tvalid = 1'b0;

    while (pending_outcomes.size() != 0) @(negedge clk);
    repeat (12) @(posedge clk);  // catch any stray result
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // receiver: random stalls, one long hold-off, in-order field compare
  // ---------------------------------------------------------------------------

  initial begin
    int gap;
    sched_outcome_t want;
    out_tready = 1'b0;
    while (!rst_n) @(negedge clk);
    forever begin
      if (rx_hold) begin
        out_tready = 1'b0;
        repeat (RX_HOLD_CYCLES) @(negedge clk);
        rx_hold = 1'b0;
      end
      gap = rx_eager ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
        out_tready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_tready = 1'b1;
      do @(posedge clk); while (!out_tvalid);
      if (pending_outcomes.size() == 0) begin
        report_mismatch($sformatf("result id=%0d valid=%0d status=%0d with no event pending",
                                  out_tdata[TID_W-1:0], out_tuser[0], out_tuser[3:1]));
      end else begin
        want = pending_outcomes.pop_front();
        if (out_tdata[TID_W-1:0] !== want.running_id)
          report_mismatch($sformatf("running_id %0d, expected %0d",
                                    out_tdata[TID_W-1:0], want.running_id));
        if (out_tuser[0] !== want.running_valid)
          report_mismatch($sformatf("running_valid %0d, expected %0d",
                                    out_tuser[0], want.running_valid));
        if (out_tuser[3:1] !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d",
                                    out_tuser[3:1], want.status));
      end
      @(negedge clk);
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: too long without a transfer on either channel ends the run
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
